### rtl/core/assert_macros.svh
// Assertion macros shared by the page mapper RTL.
// Each macro expects signals clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define HCPM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define HCPM_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/core/hcpm_pkg.sv
// Types, codes and helper functions of the handheld console page mapper.
// No dependencies; used by the channel interfaces and the top level.
package hcpm_pkg;

  localparam int HCPM_ROM_BANKS  = 512;
  localparam int HCPM_SRAM_BANKS = 16;
  localparam int HCPM_WRAM_BANKS = 8;

  localparam int MODE_W   = 3;
  localparam int ADDR_W   = 16;
  localparam int BANK_W   = 9;
  localparam int FLAGS_W  = 3;
  localparam int DMA_W    = 3;
  localparam int REGION_W = 3;
  localparam int OFFSET_W = 23;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODEL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRAM_COUNT  = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_READ     = 3'd0,
    MODE_WRITE    = 3'd1,
    MODE_SET_FIX  = 3'd2,
    MODE_SET_ROM  = 3'd3,
    MODE_SET_SRAM = 3'd4,
    MODE_SET_WRAM = 3'd5,
    MODE_SET_DMA  = 3'd6
  } mode_t;

  typedef enum logic [REGION_W-1:0] {
    RG_NONE = 3'd0,
    RG_ROM  = 3'd1,
    RG_SRAM = 3'd2,
    RG_WRAM = 3'd3,
    RG_FILL = 3'd4,
    RG_SINK = 3'd5,
    RG_ELSE = 3'd6
  } region_t;

  typedef enum logic [DMA_W-1:0] {
    DMA_OFF     = 3'd0,
    DMA_ROM     = 3'd1,
    DMA_SRAM    = 3'd2,
    DMA_VRAM    = 3'd3,
    DMA_WRAM    = 3'd4,
    DMA_INVALID = 3'd5
  } dma_t;

  localparam int FLAG_RD  = 0;
  localparam int FLAG_WR  = 1;
  localparam int FLAG_RTC = 2;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [ADDR_W-1:0]  address;
    logic [BANK_W-1:0]  bank;
    logic [FLAGS_W-1:0] ram_flags;
    logic [DMA_W-1:0]   dma_source;
  } in_item_t;

  // Remainder of a bank number by a constant, by restoring subtraction of
  // shifted copies of the divisor; only shifts that fit in nine bits count.
  function automatic logic [BANK_W-1:0] mod_by(input logic [BANK_W-1:0] value,
                                               input int divisor);
    logic [BANK_W-1:0] r;
    r = value;
    for (int k = BANK_W - 1; k >= 0; k--) begin
      if ((divisor << k) < (1 << BANK_W) && 32'(r) >= (divisor << k)) begin
        r = BANK_W'(32'(r) - (divisor << k));
      end
    end
    return r;
  endfunction

endpackage

### rtl/core/hcpm_in_if.sv
// Request channel of the page mapper: valid/ready handshake and item fields.
// Depends on hcpm_pkg for the field widths.
interface hcpm_in_if import hcpm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [ADDR_W-1:0]  address;
  logic [BANK_W-1:0]  bank;
  logic [FLAGS_W-1:0] ram_flags;
  logic [DMA_W-1:0]   dma_source;

  modport source (output valid, mode, address, bank, ram_flags, dma_source, input ready);
  modport sink (input valid, mode, address, bank, ram_flags, dma_source, output ready);
endinterface

### rtl/core/hcpm_out_if.sv
// Result channel of the page mapper: valid/ready handshake, region and offset.
// Depends on hcpm_pkg for the field widths.
interface hcpm_out_if import hcpm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [REGION_W-1:0] region;
  logic [OFFSET_W-1:0] offset;

  modport source (output valid, region, offset, input ready);
  modport sink (input valid, region, offset, output ready);
endinterface

### rtl/core/handheld_console_page_mapper_top.sv
// Top level of the handheld console page mapper.
// Depends on hcpm_pkg, hcpm_in_if, hcpm_out_if and assert_macros.svh.
//
// Usage: requests arrive on in_ch, one transfer per request. A read or write
// lookup gives exactly one transfer on out_ch carrying the region and byte
// offset; bank-setting requests only update the mapping state and give none.
// The cfg_ port writes the two configuration registers; the user must do so only
// while the block is idle, which the block itself does not enforce. Index 0 selects
// the colour-model DMA rules, index 1 holds the count of cartridge RAM banks.
// A lookup is held in the input register, then in the result register, and is
// presented on out_ch from the result register. Throughput: one request per
// cycle while out_ch takes the results, set by the single decode stage between
// the two registers.
// Reset (synchronous, rst_n low) empties both stages and returns the banks to
// their power-on values: fixed ROM bank 0, switchable ROM bank 1, cartridge
// RAM bank 0 with all flags clear, WRAM bank 1 and DMA off.
// When the receiver stalls, the result is held and the input stage keeps one
// further lookup; in_ch.ready falls only once both are full, and requests
// that give no result keep flowing while a result is held, until a lookup fills the input stage.
module handheld_console_page_mapper_top
  import hcpm_pkg::*;
#(
  parameter int ROM_BANKS  = HCPM_ROM_BANKS,
  parameter int SRAM_BANKS = HCPM_SRAM_BANKS,
  parameter int WRAM_BANKS = HCPM_WRAM_BANKS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  hcpm_in_if.sink               in_ch,
  hcpm_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "assert_macros.svh"

  localparam int RB_W = (ROM_BANKS > 1) ? $clog2(ROM_BANKS) : 1;
  localparam int SB_W = (SRAM_BANKS > 1) ? $clog2(SRAM_BANKS) : 1;
  localparam int WB_W = (WRAM_BANKS > 1) ? $clog2(WRAM_BANKS) : 1;

  logic                  color_model_r;
  logic [CFG_DATA_W-1:0] sram_count_r;

  logic [RB_W-1:0]    fixed_rom_bank_r, fixed_rom_bank_nxt;
  logic [RB_W-1:0]    switch_rom_bank_r, switch_rom_bank_nxt;
  logic [SB_W-1:0]    sram_bank_r, sram_bank_nxt;
  logic [FLAGS_W-1:0] sram_flags_r, sram_flags_nxt;
  logic [WB_W-1:0]    wram_bank_r, wram_bank_nxt;
  logic [DMA_W-1:0]   dma_src_r, dma_src_nxt;

  logic     s1_valid_r;
  in_item_t s1_item_r;
  logic     s1_lookup;
  logic     s1_adv;
  logic     in_take;

  logic                out_valid_r;
  region_t             out_region_r, region_nxt;
  logic [OFFSET_W-1:0] out_offset_r, offset_nxt;
  logic                out_unmapped;

  logic              cut_rr, cut_w;
  logic              is_write, enabled;
  logic [3:0]        page;
  logic [BANK_W-1:0] wram_sel;

  assign s1_lookup = (mode_t'(s1_item_r.mode) == MODE_READ) ||
                     (mode_t'(s1_item_r.mode) == MODE_WRITE);
  assign s1_adv    = s1_valid_r && (!s1_lookup || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_take   = in_ch.valid && in_ch.ready;

  assign out_ch.valid  = out_valid_r;
  assign out_ch.region = out_region_r;
  assign out_ch.offset = out_offset_r;

  assign out_unmapped = (out_region_r == RG_NONE) || (out_region_r == RG_ELSE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_model_r <= 1'b0;
      sram_count_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COLOR_MODEL: color_model_r <= cfg_data[0];
        CFG_SRAM_COUNT:  sram_count_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.mode       <= in_ch.mode;
      s1_item_r.address    <= in_ch.address;
      s1_item_r.bank       <= in_ch.bank;
      s1_item_r.ram_flags  <= in_ch.ram_flags;
      s1_item_r.dma_source <= in_ch.dma_source;
    end
  end

  always_comb begin
    wram_sel = {{(BANK_W - 3){1'b0}}, s1_item_r.bank[2:0]};
    if (s1_item_r.bank[2:0] == 3'd0) begin
      wram_sel = BANK_W'(1);
    end
  end

  always_comb begin
    fixed_rom_bank_nxt  = fixed_rom_bank_r;
    switch_rom_bank_nxt = switch_rom_bank_r;
    sram_bank_nxt       = sram_bank_r;
    sram_flags_nxt      = sram_flags_r;
    wram_bank_nxt       = wram_bank_r;
    dma_src_nxt         = dma_src_r;
    case (mode_t'(s1_item_r.mode))
      MODE_SET_FIX: fixed_rom_bank_nxt = RB_W'(mod_by(s1_item_r.bank, ROM_BANKS));
      MODE_SET_ROM: switch_rom_bank_nxt = RB_W'(mod_by(s1_item_r.bank, ROM_BANKS));
      MODE_SET_SRAM: begin
        sram_bank_nxt  = SB_W'(mod_by({{(BANK_W - 4){1'b0}}, s1_item_r.bank[3:0]},
                                      SRAM_BANKS));
        sram_flags_nxt = s1_item_r.ram_flags;
      end
      MODE_SET_WRAM: wram_bank_nxt = WB_W'(mod_by(wram_sel, WRAM_BANKS));
      MODE_SET_DMA:  dma_src_nxt = s1_item_r.dma_source;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fixed_rom_bank_r  <= '0;
      switch_rom_bank_r <= RB_W'(1);
      sram_bank_r       <= '0;
      sram_flags_r      <= '0;
      wram_bank_r       <= WB_W'(1);
      dma_src_r         <= DMA_OFF;
    end else if (s1_adv) begin
      fixed_rom_bank_r  <= fixed_rom_bank_nxt;
      switch_rom_bank_r <= switch_rom_bank_nxt;
      sram_bank_r       <= sram_bank_nxt;
      sram_flags_r      <= sram_flags_nxt;
      wram_bank_r       <= wram_bank_nxt;
      dma_src_r         <= dma_src_nxt;
    end
  end

  always_comb begin
    cut_rr = 1'b0;
    cut_w  = 1'b0;
    case (dma_t'(dma_src_r))
      DMA_OFF, DMA_VRAM: ;
      DMA_WRAM: begin
        cut_w  = 1'b1;
        cut_rr = !color_model_r;
      end
      default: begin
        cut_rr = 1'b1;
        cut_w  = !color_model_r;
      end
    endcase
  end

  always_comb begin
    page       = s1_item_r.address[15:12];
    is_write   = (mode_t'(s1_item_r.mode) == MODE_WRITE);
    enabled    = is_write ? sram_flags_r[FLAG_WR] : sram_flags_r[FLAG_RD];
    region_nxt = RG_NONE;
    offset_nxt = '0;
    if (page <= 4'h7) begin
      if (!is_write && !cut_rr) begin
        region_nxt = RG_ROM;
        offset_nxt = ((page <= 4'h3) ? (OFFSET_W'(fixed_rom_bank_r) << 14)
                                     : (OFFSET_W'(switch_rom_bank_r) << 14))
                     | OFFSET_W'(s1_item_r.address[13:0]);
      end
    end else if (page == 4'hA || page == 4'hB) begin
      if (!cut_rr) begin
        if (!enabled || (!sram_flags_r[FLAG_RTC] && sram_count_r == '0)) begin
          region_nxt = is_write ? RG_SINK : RG_FILL;
          offset_nxt = OFFSET_W'(s1_item_r.address[12:0]);
        end else if (!sram_flags_r[FLAG_RTC]) begin
          region_nxt = RG_SRAM;
          offset_nxt = (OFFSET_W'(sram_bank_r) << 13) | OFFSET_W'(s1_item_r.address[12:0]);
        end
      end
    end else if (page >= 4'hC && page <= 4'hE) begin
      if (!cut_w) begin
        region_nxt = RG_WRAM;
        offset_nxt = ((page == 4'hD) ? (OFFSET_W'(wram_bank_r) << 12) : '0)
                     | OFFSET_W'(s1_item_r.address[11:0]);
      end
    end else begin
      region_nxt = RG_ELSE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_lookup) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_lookup) begin
      out_region_r <= region_nxt;
      out_offset_r <= offset_nxt;
    end
  end

  `HCPM_ASSERT(a_lookup_gives_result, s1_adv && s1_lookup |=> out_valid_r, "lookup lost")
  `HCPM_NEVER(a_wram_bank_zero, wram_bank_r == '0, "WRAM bank register holds zero")
  `HCPM_ASSERT(a_rom_bank_range, 32'(switch_rom_bank_r) < ROM_BANKS, "ROM bank out of range")
  `HCPM_ASSERT(a_empty_offset, out_valid_r && out_unmapped |-> out_offset_r == '0, "offset set")

endmodule
